// File: rtl/axr_pkg.sv
// shared types, constants and microcode table for the add-xor-rotate cipher
package axr_pkg;

  localparam int WORD_W       = 64;
  localparam int NUM_WORDS    = 8;
  localparam int CNT_W        = $clog2(NUM_WORDS);
  localparam int SETUP_ROUNDS = 64;
  localparam int ROUND_W      = $clog2(SETUP_ROUNDS + 1);
  localparam int KEY_WORDS    = 4;
  localparam int NONCE_WORDS  = 2;
  localparam int CFG_IDX_W    = 3;
  localparam int COUNT_W      = 4;
  localparam int PC_W         = 3;

  localparam logic [CFG_IDX_W-1:0] REG_KEY_0   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_1   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_2   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_3   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_NONCE_0 = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_NONCE_1 = 3'd5;

  localparam logic [COUNT_W-1:0] FULL_COUNT = 4'd8;

  typedef logic [PC_W-1:0] pc_t;

  localparam pc_t PC_WAIT     = 3'd0;
  localparam pc_t PC_DISPATCH = 3'd1;
  localparam pc_t PC_LOAD     = 3'd2;
  localparam pc_t PC_SUM      = 3'd3;
  localparam pc_t PC_MIX      = 3'd4;
  localparam pc_t PC_EMIT     = 3'd5;

  typedef enum logic [2:0] {
    OP_WAIT,
    OP_DISPATCH,
    OP_LOAD,
    OP_SUM,
    OP_MIX,
    OP_EMIT
  } op_t;

  typedef enum logic [2:0] {
    COND_ALWAYS,
    COND_IN_VALID,
    COND_KIND,
    COND_CNT_LAST,
    COND_ROUND_LAST,
    COND_OUT_FREE
  } cond_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    pc_t   target_true;
    pc_t   target_false;
  } ctrl_t;

  typedef struct packed {
    logic in_valid;
    logic kind;
    logic cnt_last;
    logic round_last;
    logic out_free;
  } status_t;

  function automatic ctrl_t microcode(input pc_t pc);
    ctrl_t w;
    case (pc)
      PC_WAIT:     w = '{OP_WAIT,     COND_IN_VALID,   PC_DISPATCH, PC_WAIT};
      PC_DISPATCH: w = '{OP_DISPATCH, COND_KIND,       PC_LOAD,     PC_MIX};
      PC_LOAD:     w = '{OP_LOAD,     COND_ALWAYS,     PC_SUM,      PC_SUM};
      PC_SUM:      w = '{OP_SUM,      COND_CNT_LAST,   PC_MIX,      PC_SUM};
      PC_MIX:      w = '{OP_MIX,      COND_ROUND_LAST, PC_EMIT,     PC_MIX};
      PC_EMIT:     w = '{OP_EMIT,     COND_OUT_FREE,   PC_WAIT,     PC_EMIT};
      default:     w = '{OP_WAIT,     COND_ALWAYS,     PC_WAIT,     PC_WAIT};
    endcase
    return w;
  endfunction

  function automatic logic [WORD_W-1:0] rotl2(input logic [WORD_W-1:0] v);
    return {v[WORD_W-3:0], v[WORD_W-1:WORD_W-2]};
  endfunction

endpackage

// File: rtl/axr_sequencer.sv
// microcode sequencer: step counter, control table and conditional jumps
module axr_sequencer
  import axr_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  status_t status,
  output ctrl_t   ctrl
);

  pc_t  pc;
  pc_t  pc_next;
  logic taken;

  assign ctrl = microcode(pc);

  always_comb begin
    case (ctrl.cond)
      COND_ALWAYS:     taken = 1'b1;
      COND_IN_VALID:   taken = status.in_valid;
      COND_KIND:       taken = status.kind;
      COND_CNT_LAST:   taken = status.cnt_last;
      COND_ROUND_LAST: taken = status.round_last;
      COND_OUT_FREE:   taken = status.out_free;
      default:         taken = 1'b1;
    endcase
    pc_next = taken ? ctrl.target_true : ctrl.target_false;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= PC_WAIT;
    end else begin
      pc <= pc_next;
    end
  end

  a_accept_dispatch: assert property (@(posedge clk) disable iff (rst)
    (pc == PC_WAIT && status.in_valid) |=> (pc == PC_DISPATCH))
    else $error("transfer not followed by dispatch");

  a_mix_holds: assert property (@(posedge clk) disable iff (rst)
    (pc == PC_MIX && !status.round_last) |=> (pc == PC_MIX))
    else $error("mixing left before last round");

  a_emit_return: assert property (@(posedge clk) disable iff (rst)
    (pc == PC_EMIT && status.out_free) |=> (pc == PC_WAIT))
    else $error("emit did not return to wait");

  a_sum_to_mix: assert property (@(posedge clk) disable iff (rst)
    (pc == PC_SUM && status.cnt_last) |=> (pc == PC_MIX))
    else $error("sum pass did not hand over to mixing");

endmodule

// File: rtl/axr_datapath.sv
// state words, session sum, mixing step and output register
module axr_datapath
  import axr_pkg::*;
(
  input  logic                                 clk,
  input  logic                                 rst,
  input  ctrl_t                                ctrl,
  output status_t                              status,
  input  logic [KEY_WORDS-1:0][WORD_W-1:0]     key,
  input  logic [NONCE_WORDS-1:0][WORD_W-1:0]   nonce,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 kind,
  input  logic [WORD_W-1:0]                    data_in,
  input  logic [COUNT_W-1:0]                   byte_count,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [WORD_W-1:0]                    data_out,
  output logic [COUNT_W-1:0]                   byte_count_out
);

  logic [NUM_WORDS-1:0][WORD_W-1:0] words;
  logic [WORD_W-1:0]                session_sum;
  logic [WORD_W-1:0]                run;
  logic [CNT_W-1:0]                 cnt;
  logic [ROUND_W-1:0]               rounds;
  logic                             kind_r;
  logic [WORD_W-1:0]                data_r;
  logic [COUNT_W-1:0]               count_r;

  logic [WORD_W-1:0]  run_in;
  logic [WORD_W-1:0]  mixed;
  logic [WORD_W-1:0]  run_next;
  logic [WORD_W-1:0]  stream;
  logic [WORD_W-1:0]  mask;
  logic [COUNT_W-1:0] count_sat;
  logic               accept;
  logic               out_free;

  assign in_stall = (ctrl.op != OP_WAIT);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  assign run_in   = (cnt == '0) ? session_sum : run;
  assign mixed    = rotl2((words[0] + words[1] + run_in) ^ words[0]);
  assign run_next = run_in + mixed + WORD_W'(cnt);
  assign stream   = ((words[1] + words[7]) ^ words[3]) ^ words[5];

  assign count_sat = (count_r > FULL_COUNT) ? FULL_COUNT : count_r;

  always_comb begin
    for (int b = 0; b < 8; b++) begin
      mask[b*8 +: 8] = (COUNT_W'(b) < count_sat) ? 8'hFF : 8'h00;
    end
  end

  assign status.in_valid   = in_valid;
  assign status.kind       = kind_r;
  assign status.cnt_last   = (cnt == CNT_W'(NUM_WORDS - 1));
  assign status.round_last = (cnt == CNT_W'(NUM_WORDS - 1)) && (rounds == '0);
  assign status.out_free   = out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      words       <= '0;
      session_sum <= '0;
      run         <= '0;
      cnt         <= '0;
      rounds      <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (ctrl.op == OP_EMIT && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (ctrl.op)
        OP_WAIT: begin
        end
        OP_DISPATCH: begin
          cnt    <= '0;
          rounds <= kind_r ? ROUND_W'(SETUP_ROUNDS) : '0;
        end
        OP_LOAD: begin
          words[0]    <= key[0] ^ nonce[0];
          words[1]    <= key[1] ^ nonce[1];
          words[2]    <= key[2];
          words[3]    <= key[3];
          words[4]    <= '0;
          words[5]    <= '0;
          words[6]    <= '0;
          words[7]    <= '0;
          session_sum <= '0;
          cnt         <= '0;
        end
        OP_SUM: begin
          session_sum <= session_sum + words[0];
          for (int k = 0; k < NUM_WORDS - 1; k++) begin
            words[k] <= words[k+1];
          end
          words[NUM_WORDS-1] <= words[0];
          cnt <= cnt + 1'b1;
        end
        OP_MIX: begin
          for (int k = 0; k < NUM_WORDS - 1; k++) begin
            words[k] <= words[k+1];
          end
          words[NUM_WORDS-1] <= mixed;
          run <= run_next;
          cnt <= cnt + 1'b1;
          if (status.cnt_last && rounds != '0) begin
            rounds <= rounds - 1'b1;
          end
        end
        OP_EMIT: begin
        end
        default: begin
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r  <= kind;
      data_r  <= data_in;
      count_r <= byte_count;
    end
    if (ctrl.op == OP_EMIT && out_free) begin
      data_out       <= (data_r ^ stream) & mask;
      byte_count_out <= count_sat;
    end
  end

endmodule

// File: rtl/add_xor_rotate_stream_cipher.sv
// top level: configuration registers, sequencer and datapath
// a continue item runs one eight-step mixing round before its result is emitted
// a new item is accepted only after the previous result has been emitted
// a start item adds a key load, an eight-step sum pass and SETUP_ROUNDS setup mixing rounds
// reset: synchronous, clears key, nonce, state words, session sum and sequencer
module add_xor_rotate_stream_cipher
  import axr_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [WORD_W-1:0]    cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 kind,
  input  logic [WORD_W-1:0]    data_in,
  input  logic [COUNT_W-1:0]   byte_count,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [WORD_W-1:0]    data_out,
  output logic [COUNT_W-1:0]   byte_count_out
);

  logic [KEY_WORDS-1:0][WORD_W-1:0]   key;
  logic [NONCE_WORDS-1:0][WORD_W-1:0] nonce;
  ctrl_t                              ctrl;
  status_t                            status;

  always_ff @(posedge clk) begin
    if (rst) begin
      key   <= '0;
      nonce <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_KEY_0:   key[0]   <= cfg_data;
        REG_KEY_1:   key[1]   <= cfg_data;
        REG_KEY_2:   key[2]   <= cfg_data;
        REG_KEY_3:   key[3]   <= cfg_data;
        REG_NONCE_0: nonce[0] <= cfg_data;
        REG_NONCE_1: nonce[1] <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  axr_sequencer u_sequencer (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .ctrl   (ctrl)
  );

  axr_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .ctrl           (ctrl),
    .status         (status),
    .key            (key),
    .nonce          (nonce),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .kind           (kind),
    .data_in        (data_in),
    .byte_count     (byte_count),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .data_out       (data_out),
    .byte_count_out (byte_count_out)
  );

endmodule

// File: test/axr_cipher_checker.sv
// checker for the add-xor-rotate stream cipher: predicts each result and compares it
module axr_cipher_checker
  import axr_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [WORD_W-1:0]    cfg_data,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  logic                 kind,
  input  logic [WORD_W-1:0]    data_in,
  input  logic [COUNT_W-1:0]   byte_count,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  logic [WORD_W-1:0]    data_out,
  input  logic [COUNT_W-1:0]   byte_count_out,
  output int                   errors,
  output int                   pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [WORD_W-1:0]  data;
    logic [COUNT_W-1:0] count;
  } cipher_out_t;

  logic [WORD_W-1:0] key_reg [KEY_WORDS];
  logic [WORD_W-1:0] nonce_reg [NONCE_WORDS];
  logic [WORD_W-1:0] mix_state [NUM_WORDS];
  logic [WORD_W-1:0] round_seed;
  cipher_out_t       cipher_due [$];

  function automatic void stir_round();
    logic [WORD_W-1:0] run;
    logic [WORD_W-1:0] t;
    run = round_seed;
    for (int i = 0; i < NUM_WORDS; i++) begin
      t = (mix_state[i] + mix_state[(i + 1) % NUM_WORDS] + run) ^ mix_state[i];
      mix_state[i] = {t[WORD_W-3:0], t[WORD_W-1:WORD_W-2]};
      run = run + mix_state[i] + WORD_W'(i);
    end
  endfunction

  function automatic void start_session();
    for (int i = 0; i < KEY_WORDS; i++) begin
      mix_state[i] = key_reg[i];
      mix_state[i + KEY_WORDS] = '0;
    end
    mix_state[0] ^= nonce_reg[0];
    mix_state[1] ^= nonce_reg[1];
    round_seed = '0;
    for (int i = 0; i < NUM_WORDS; i++) round_seed += mix_state[i];
    repeat (SETUP_ROUNDS) stir_round();
  endfunction

  function automatic cipher_out_t cipher_block(input logic k, input logic [WORD_W-1:0] d,
                                               input logic [COUNT_W-1:0] c);
    logic [COUNT_W-1:0] n;
    logic [WORD_W-1:0]  stream;
    logic [WORD_W-1:0]  keep;
    n = (c > FULL_COUNT) ? FULL_COUNT : c;
    if (k) start_session();
    stir_round();
    stream = (mix_state[1] + mix_state[7]) ^ mix_state[3] ^ mix_state[5];
    keep = (n == FULL_COUNT) ? '1 : (WORD_W'(1) << (8 * n)) - WORD_W'(1);
    return '{data: (d ^ stream) & keep, count: n};
  endfunction

  always @(posedge clk) begin
    cipher_out_t want;
    if (rst) begin
      foreach (key_reg[i]) key_reg[i] = '0;
      foreach (nonce_reg[i]) nonce_reg[i] = '0;
      foreach (mix_state[i]) mix_state[i] = '0;
      round_seed = '0;
      cipher_due.delete();
      errors = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_KEY_0, REG_KEY_1, REG_KEY_2, REG_KEY_3: key_reg[cfg_index - REG_KEY_0] = cfg_data;
          REG_NONCE_0, REG_NONCE_1: nonce_reg[cfg_index - REG_NONCE_0] = cfg_data;
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (cipher_due.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("%0t: unexpected result data_out %h byte_count_out %0d",
                     $time, data_out, byte_count_out);
        end else begin
          want = cipher_due.pop_front();
          if (data_out !== want.data || byte_count_out !== want.count) begin
            errors++;
            if (errors <= 10)
              $display("%0t: mismatch, expected data_out %h byte_count_out %0d, got %h %0d",
                       $time, want.data, want.count, data_out, byte_count_out);
          end
        end
      end
      if (in_valid && !in_stall)
        cipher_due.push_back(cipher_block(kind, data_in, byte_count));
    end
    pending = cipher_due.size();
  end

endmodule

// File: test/add_xor_rotate_stream_cipher_tb.sv
// testbench top for the add-xor-rotate stream cipher: clock, reset, stimulus and verdict
module add_xor_rotate_stream_cipher_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import axr_pkg::*;

  localparam int LONG_HOLD = 600;
  localparam int PHASES    = 8;
  localparam int PHASE_LEN = 142;

  typedef enum {FLOW_OPEN, FLOW_COIN, FLOW_CHOKED, FLOW_TOGGLE} flow_t;

  logic                 clk;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [WORD_W-1:0]    cfg_data;
  logic                 in_valid;
  logic                 in_stall;
  logic                 kind;
  logic [WORD_W-1:0]    data_in;
  logic [COUNT_W-1:0]   byte_count;
  logic                 out_valid;
  logic                 out_stall;
  logic [WORD_W-1:0]    data_out;
  logic [COUNT_W-1:0]   byte_count_out;
  int                   errors;
  int                   pending;

  int burst_left    = 0;
  int msg_left      = 0;
  int hold_requests = 0;
  int holds_served  = 0;

  add_xor_rotate_stream_cipher i_dut (.*);

  axr_cipher_checker i_check (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("DONE: errors detected");
    $finish;
  end

  // receiver stall pattern, with a long hold-off on request
  initial begin
    flow_t mode;
    int    span;
    out_stall = 1'b0;
    wait (rst === 1'b0);
    forever begin
      if (holds_served != hold_requests) begin
        repeat (LONG_HOLD) begin
          @(negedge clk);
          out_stall = 1'b1;
        end
        holds_served++;
      end
      mode = flow_t'($urandom_range(0, 3));
      span = $urandom_range(10, 150);
      repeat (span) begin
        @(negedge clk);
        case (mode)
          FLOW_OPEN:   out_stall = 1'b0;
          FLOW_COIN:   out_stall = $urandom_range(0, 1);
          FLOW_CHOKED: out_stall = ($urandom_range(0, 7) != 0);
          default:     out_stall = ~out_stall;
        endcase
      end
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] value);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = value;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic send(input logic k, input logic [WORD_W-1:0] d, input logic [COUNT_W-1:0] c);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      repeat (gap) begin
        @(negedge clk);
        in_valid = 1'b0;
      end
    end
    burst_left--;
    @(negedge clk);
    in_valid = 1'b1;
    kind = k;
    data_in = d;
    byte_count = c;
    do @(posedge clk); while (in_stall);
  endtask

  function automatic logic [WORD_W-1:0] pick_word();
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // mostly whole messages: a start transfer, full blocks, a final block of one to eight bytes
  task automatic random_item();
    logic               k;
    logic [COUNT_W-1:0] c;
    if ($urandom_range(0, 7) == 0) begin
      k = ($urandom_range(0, 3) == 0);
      c = COUNT_W'($urandom_range(0, 15));
    end else begin
      k = (msg_left == 0);
      if (k) msg_left = $urandom_range(1, 24);
      c = (msg_left == 1) ? COUNT_W'($urandom_range(1, 8)) : FULL_COUNT;
      msg_left--;
    end
    send(k, {$urandom, $urandom}, c);
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    kind = 1'b0;
    data_in = '0;
    byte_count = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // no start since reset
    send(1'b0, '0, FULL_COUNT);
    send(1'b0, '1, FULL_COUNT);
    send(1'b0, {$urandom, $urandom}, 4'd0);
    wait_idle();

    write_reg(REG_KEY_0, '1);
    write_reg(REG_KEY_1, '1);
    write_reg(REG_KEY_2, '1);
    write_reg(REG_KEY_3, '1);
    write_reg(REG_NONCE_0, '1);
    write_reg(REG_NONCE_1, '1);
    // new key only counts from the next start
    send(1'b0, {$urandom, $urandom}, FULL_COUNT);
    send(1'b1, '1, FULL_COUNT);
    send(1'b0, '0, 4'd1);
    send(1'b0, '1, 4'd7);
    send(1'b0, '1, 4'd9);
    send(1'b0, '1, 4'd15);
    send(1'b0, '1, 4'd0);
    send(1'b1, '1, 4'd0);
    send(1'b1, '1, 4'd15);
    wait_idle();

    write_reg(REG_KEY_0, '0);
    write_reg(REG_KEY_1, '0);
    write_reg(REG_KEY_2, '0);
    write_reg(REG_KEY_3, '0);
    write_reg(REG_NONCE_0, '0);
    write_reg(REG_NONCE_1, '0);
    send(1'b1, {$urandom, $urandom}, FULL_COUNT);
    send(1'b0, {$urandom, $urandom}, 4'd3);
    wait_idle();

    write_reg(REG_KEY_0, {32{2'b10}});
    write_reg(REG_KEY_2, {32{2'b01}});
    write_reg(REG_NONCE_0, {32{2'b01}});
    write_reg(REG_NONCE_1, {32{2'b10}});
    send(1'b1, 64'h0123_4567_89ab_cdef, FULL_COUNT);
    send(1'b0, 64'hfedc_ba98_7654_3210, 4'd4);
    wait_idle();

    for (int p = 0; p < PHASES; p++) begin
      for (int r = REG_KEY_0; r <= REG_NONCE_1; r++)
        if (p == 0 || $urandom_range(0, 1)) write_reg(CFG_IDX_W'(r), pick_word());
      if (p == PHASES / 2) hold_requests++;
      repeat (PHASE_LEN) random_item();
      wait_idle();
    end

    repeat (30) @(negedge clk);
    if (errors == 0 && pending == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule
